FILE: src/ftg_pkg.sv
// Shared constants, types and table builder for the filmic tonemap pipeline.
package ftg_pkg;

    localparam int IN_W     = 24;   // input channel width
    localparam int ONE_BITS = 16;   // internal Q.16 fraction bits
    localparam int IN_FRAC_BITS_DEF     = 16;
    localparam int OUT_BITS_DEF         = 16;
    localparam int GAMMA_TABLE_BITS_DEF = 10;
    localparam int TAB_EXTRA = 4;   // guard bits kept in gamma table entries

    localparam int V_W   = 24;      // curve input, Q8.16
    localparam int IP_W  = 40;      // input matrix product
    localparam int IS_W  = 42;      // input matrix row sum
    localparam int NP_W  = 49;      // v*(v+A)
    localparam int NUM_W = 50;      // signed numerator
    localparam int CVP_W = 40;      // C*v
    localparam int DEN_W = 50;      // denominator
    localparam int Q_W   = 18;      // curve quotient magnitude
    localparam int T_W   = Q_W + 1; // signed curve value
    localparam int N_W   = 66;      // dividend mag*2^16 + den/2
    localparam int OC_W  = 18;      // output matrix coefficient
    localparam int OP_W  = OC_W + T_W;
    localparam int OS_W  = OP_W + 2;
    localparam int X_W   = ONE_BITS + 1;

    localparam logic [V_W-1:0]   V_CAP = 24'hFF_FFFF;
    localparam logic [V_W:0]     CRV_A = 25'd1611;
    localparam logic [NUM_W-1:0] CRV_B = 50'd388853;
    localparam logic [15:0]      CRV_C = 16'd64470;
    localparam logic [V_W:0]     CRV_D = 25'd28374;
    localparam logic [DEN_W-1:0] CRV_E = 50'd1022550109;

    localparam logic [15:0] IN_MAT [3][3] = '{
        '{16'd39137, 16'd23238, 16'd3161},
        '{16'd4981,  16'd59529, 16'd1026},
        '{16'd1861,  16'd8771,  16'd54904}
    };

    localparam logic signed [OC_W-1:0] OUT_MAT [3][3] = '{
        '{18'sd105169, -18'sd34805, -18'sd4828},
        '{-18'sd6690,  18'sd72622,  -18'sd396},
        '{-18'sd214,   -18'sd4768,  18'sd70518}
    };

    typedef struct packed {
        logic en;     // pipeline advance
        logic valid;  // item entering the unit
    } t_stage_ctl;

    // Exact floor of 2^tf * (k/2^g)^(5/11), by bisection on wide integers.
    function automatic int gamma_entry(int k, int g, int tf);
        logic [511:0] rhs;
        logic [511:0] lhs;
        int lo;
        int hi;
        int mid;
        rhs = 512'(k);
        for (int i = 0; i < 4; i++) rhs = rhs * 512'(k);
        rhs = rhs << (11 * tf);
        lo = 0;
        hi = 1 << tf;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            lhs = 512'(mid);
            for (int i = 0; i < 10; i++) lhs = lhs * 512'(mid);
            lhs = lhs << (5 * g);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

endpackage

FILE: src/filmic_tonemap_gamma_top.sv
// Top level of the filmic tonemap pipeline: matrices, per-channel units, output skid.
//
// Usage: one linear RGB pixel per transfer on the slave stream (three unsigned
// 24-bit channels, Q8.16 by default), one display pixel per transfer on the
// master stream (three unsigned Q0.OUT_BITS channels). Pixels are independent.
// Throughput: one pixel per clock while the receiver keeps tready high.
// Depth: 29 register stages from slave input to master output: 2 input matrix
// stages, 21 curve stages (3 arithmetic, 18 one-bit divider steps set the depth),
// 2 output matrix stages, 3 gamma stages, output register.
// The gamma table is a per-channel ROM built at elaboration, read at two
// addresses each cycle.
// Stall: the whole pipeline advances together. A result that meets a stalled
// output register drops into a one-entry skid buffer; while the skid is full
// the pipeline holds and tready on the slave side is low. Nothing is dropped.
// Reset: synchronous, active low; clears all valid bits, including those of the
// output register and the skid. No clearing pass, so tready on the slave side is
// high as soon as reset is released.
module filmic_tonemap_gamma_top #(
    parameter int IN_FRAC_BITS     = ftg_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_BITS         = ftg_pkg::OUT_BITS_DEF,
    parameter int GAMMA_TABLE_BITS = ftg_pkg::GAMMA_TABLE_BITS_DEF,
    localparam int OUT_DW          = ((3 * OUT_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [71:0]       i_s_axis_tdata,   // in_red, in_green, in_blue
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata    // out_red, out_green, out_blue, zero pad
);
    import ftg_pkg::*;

    logic       w_adv;    // whole pipeline moves this cycle
    t_stage_ctl w_c_ctl;
    t_stage_ctl w_g_ctl;

    logic r_skid_valid;
    logic r_out_valid;

    assign w_adv           = !r_skid_valid;
    assign o_s_axis_tready = w_adv;

    // ---- input matrix: products, then sum / round / saturate
    logic [IN_W-1:0] w_px [3];
    assign w_px[0] = i_s_axis_tdata[23:0];
    assign w_px[1] = i_s_axis_tdata[47:24];
    assign w_px[2] = i_s_axis_tdata[71:48];

    logic            r_m1_valid;
    logic [IP_W-1:0] r_ip [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_adv) begin
            r_m1_valid <= i_s_axis_tvalid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_ip[i][j] <= IP_W'(IN_MAT[i][j]) * IP_W'(w_px[j]);
                end
            end
        end
    end

    logic [IS_W-1:0] w_is [3];
    logic [IS_W-1:0] w_ir [3];
    logic            r_m2_valid;
    logic [V_W-1:0]  r_v [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_is[i] = IS_W'(r_ip[i][0]) + IS_W'(r_ip[i][1]) + IS_W'(r_ip[i][2]);
            w_ir[i] = (w_is[i] + (IS_W'(1) << (IN_FRAC_BITS - 1))) >> IN_FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_adv) begin
            r_m2_valid <= r_m1_valid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_v[i] <= (w_ir[i] > IS_W'(V_CAP)) ? V_CAP : w_ir[i][V_W-1:0];
            end
        end
    end

    // ---- per-channel curve; all lanes carry the same valid, lane 0 leads
    assign w_c_ctl = '{en: w_adv, valid: r_m2_valid};

    logic           w_c_valid [3];
    logic [Q_W-1:0] w_q   [3];
    logic           w_neg [3];

    for (genvar c = 0; c < 3; c++) begin : g_curve
        ftg_curve u_curve (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_c_ctl),
            .i_v     (r_v[c]),
            .o_valid (w_c_valid[c]),
            .o_q     (w_q[c]),
            .o_neg   (w_neg[c])
        );
    end

    // ---- output matrix: products, then sum / clamp / round / cap
    logic signed [T_W-1:0] w_t [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_t[j] = w_neg[j] ? -$signed({1'b0, w_q[j]}) : $signed({1'b0, w_q[j]});
        end
    end

    logic                   r_o1_valid;
    logic signed [OP_W-1:0] r_op [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_valid <= 1'b0;
        end else if (w_adv) begin
            r_o1_valid <= w_c_valid[0];
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_op[i][j] <= OP_W'(OUT_MAT[i][j]) * OP_W'(w_t[j]);
                end
            end
        end
    end

    logic signed [OS_W-1:0] w_w  [3];
    logic [OS_W-1:0]        w_xr [3];
    logic                   r_o2_valid;
    logic [X_W-1:0]         r_x [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_w[i]  = OS_W'(r_op[i][0]) + OS_W'(r_op[i][1]) + OS_W'(r_op[i][2]);
            w_xr[i] = OS_W'(w_w[i] + OS_W'(32768)) >> 16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o2_valid <= 1'b0;
        end else if (w_adv) begin
            r_o2_valid <= r_o1_valid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                if (w_w[i] <= 0) r_x[i] <= '0;
                else if (w_xr[i] > OS_W'(65536)) r_x[i] <= X_W'(65536);
                else r_x[i] <= w_xr[i][X_W-1:0];
            end
        end
    end

    // ---- per-channel gamma; lane 0 valid drives the output stage
    assign w_g_ctl = '{en: w_adv, valid: r_o2_valid};

    logic                w_g_valid [3];
    logic                w_p_valid;
    logic [OUT_BITS-1:0] w_y [3];

    for (genvar c = 0; c < 3; c++) begin : g_gamma
        ftg_gamma #(
            .OUT_BITS         (OUT_BITS),
            .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
        ) u_gamma (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_g_ctl),
            .i_x     (r_x[c]),
            .o_valid (w_g_valid[c]),
            .o_y     (w_y[c])
        );
    end

    assign w_p_valid = w_g_valid[0];

    // ---- output register plus one-entry skid
    logic [OUT_DW-1:0] w_p_data;
    logic [OUT_DW-1:0] r_out_data;
    logic [OUT_DW-1:0] r_skid_data;

    assign w_p_data = OUT_DW'({w_y[2], w_y[1], w_y[0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_adv) begin
            if (w_p_valid && r_out_valid && !i_m_axis_tready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= w_p_valid || (r_out_valid && !i_m_axis_tready);
            end
        end else if (i_m_axis_tready) begin
            r_skid_valid <= 1'b0;   // skid moves into the output register
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_p_valid && (!r_out_valid || i_m_axis_tready)) begin
                r_out_data <= w_p_data;
            end
            if (w_p_valid && r_out_valid && !i_m_axis_tready) begin
                r_skid_data <= w_p_data;
            end
        end else if (i_m_axis_tready) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---- checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a pixel while the output register is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_axis_tready && w_p_valid))
        else $error("skid filled without a stalled output");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_m_axis_tready |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid changed while the receiver stalled");

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_c_valid[1] == w_c_valid[0]) && (w_c_valid[2] == w_c_valid[0]) &&
        (w_g_valid[1] == w_g_valid[0]) && (w_g_valid[2] == w_g_valid[0]))
        else $error("channel lanes out of step");

endmodule

FILE: src/ftg_curve.sv
// Rational filmic curve for one channel: multiplies, then a bit-per-stage divider.
module ftg_curve (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ftg_pkg::t_stage_ctl         i_ctl,
    input  logic [ftg_pkg::V_W-1:0]     i_v,
    output logic                        o_valid,
    output logic [ftg_pkg::Q_W-1:0]     o_q,
    output logic                        o_neg
);
    import ftg_pkg::*;

    // stage A: v*(v+A) and C*v
    logic              r_a_valid;
    logic [NP_W-1:0]   r_nump;
    logic [CVP_W-1:0]  r_cvp;
    logic [V_W-1:0]    r_v_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_a_valid <= i_ctl.valid;
        end
        if (i_ctl.en) begin
            r_nump <= NP_W'(i_v) * NP_W'({1'b0, i_v} + CRV_A);
            r_cvp  <= CVP_W'(i_v) * CVP_W'(CRV_C);
            r_v_a  <= i_v;
        end
    end

    // stage B: numerator, rounded C*v, denominator product
    logic [V_W-1:0]          w_cv;
    logic                    r_b_valid;
    logic signed [NUM_W-1:0] r_num;
    logic [NP_W-1:0]         r_denp;

    assign w_cv = V_W'((r_cvp + CVP_W'(32768)) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_b_valid <= r_a_valid;
        end
        if (i_ctl.en) begin
            r_num  <= $signed({1'b0, r_nump} - CRV_B);
            r_denp <= NP_W'(r_v_a) * NP_W'({1'b0, w_cv} + CRV_D);
        end
    end

    // stage C: sign/magnitude and rounded dividend
    logic [NUM_W-1:0] w_mag;
    logic [DEN_W-1:0] w_den;
    logic [N_W-1:0]   w_n;

    assign w_mag = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign w_den = DEN_W'(r_denp) + CRV_E;
    assign w_n   = {w_mag[N_W-ONE_BITS-1:0], 16'd0} + N_W'(w_den >> 1);

    // divider stages; quotient is known to fit Q_W bits, so remainder starts below den
    logic             r_d_valid [Q_W+1];
    logic [DEN_W-1:0] r_rem     [Q_W+1];
    logic [Q_W-1:0]   r_low     [Q_W+1];
    logic [Q_W-1:0]   r_quo     [Q_W+1];
    logic [DEN_W-1:0] r_den     [Q_W+1];
    logic             r_neg     [Q_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_d_valid[0] <= r_b_valid;
        end
        if (i_ctl.en) begin
            r_rem[0] <= DEN_W'(w_n >> Q_W);
            r_low[0] <= w_n[Q_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= w_den;
            r_neg[0] <= r_num[NUM_W-1];
        end
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_div
        logic [DEN_W:0] w_trial;
        logic           w_ge;
        logic [DEN_W:0] w_diff;

        assign w_trial = {r_rem[s], r_low[s][Q_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[s]};
        assign w_diff  = w_trial - {1'b0, r_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[s+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_d_valid[s+1] <= r_d_valid[s];
            end
            if (i_ctl.en) begin
                r_rem[s+1] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low[s+1] <= {r_low[s][Q_W-2:0], 1'b0};
                r_quo[s+1] <= {r_quo[s][Q_W-2:0], w_ge};
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign o_valid = r_d_valid[Q_W];
    assign o_q     = r_quo[Q_W];
    assign o_neg   = r_neg[Q_W];

endmodule

FILE: src/ftg_gamma.sv
// Gamma 1/2.2 for one channel: table ROM with two reads, interpolation, rounding.
module ftg_gamma #(
    parameter int OUT_BITS         = ftg_pkg::OUT_BITS_DEF,
    parameter int GAMMA_TABLE_BITS = ftg_pkg::GAMMA_TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ftg_pkg::t_stage_ctl         i_ctl,
    input  logic [ftg_pkg::X_W-1:0]     i_x,
    output logic                        o_valid,
    output logic [OUT_BITS-1:0]         o_y
);
    import ftg_pkg::*;

    localparam int TAB_FRAC = OUT_BITS + TAB_EXTRA;
    localparam int TW       = TAB_FRAC + 1;
    localparam int TAB_SIZE = (1 << GAMMA_TABLE_BITS) + 1;
    localparam int AW       = GAMMA_TABLE_BITS + 1;
    localparam int GS       = ONE_BITS - GAMMA_TABLE_BITS;
    localparam int PW       = TW + GS;

    typedef logic [TW-1:0] t_rom [TAB_SIZE];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < TAB_SIZE; k++) begin
            rom[k] = TW'(gamma_entry(k, GAMMA_TABLE_BITS, TAB_FRAC));
        end
        return rom;
    endfunction

    localparam t_rom GAM_ROM = build_rom();

    logic [AW-1:0] w_idx;
    logic [AW-1:0] w_idx1;
    logic [GS-1:0] w_frac;

    assign w_idx  = i_x[X_W-1:GS];
    assign w_frac = i_x[GS-1:0];
    // top entry has no right neighbor; fraction is zero there anyway
    assign w_idx1 = (w_idx == AW'(TAB_SIZE - 1)) ? w_idx : w_idx + AW'(1);

    logic          r_r_valid;
    logic [TW-1:0] r_y0;
    logic [TW-1:0] r_y1;
    logic [GS-1:0] r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_r_valid <= i_ctl.valid;
        end
        if (i_ctl.en) begin
            r_y0   <= GAM_ROM[w_idx];
            r_y1   <= GAM_ROM[w_idx1];
            r_frac <= w_frac;
        end
    end

    logic [PW-1:0] w_prod;
    logic          r_i_valid;
    logic [TW-1:0] r_yi;

    assign w_prod = PW'(r_y1 - r_y0) * PW'(r_frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_i_valid <= r_r_valid;
        end
        if (i_ctl.en) begin
            r_yi <= r_y0 + TW'((w_prod + PW'(1 << (GS - 1))) >> GS);
        end
    end

    logic [TW-TAB_EXTRA-1:0] w_o;
    logic                    r_o_valid;
    logic [OUT_BITS-1:0]     r_o;

    assign w_o = (TW-TAB_EXTRA)'((r_yi + TW'(1 << (TAB_EXTRA - 1))) >> TAB_EXTRA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_o_valid <= r_i_valid;
        end
        if (i_ctl.en) begin
            r_o <= w_o[OUT_BITS] ? {OUT_BITS{1'b1}} : w_o[OUT_BITS-1:0];
        end
    end

    assign o_valid = r_o_valid;
    assign o_y     = r_o;

endmodule

FILE: sim/tb_top.sv
// Testbench for the filmic tonemap pipeline: random and directed pixels, scoreboard check.
module tb_top;

    localparam int OUT_DW   = 48;
    localparam int TAB_N    = 1025;
    localparam int LATENCY  = 29;
    localparam int N_RANDOM = 800;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [71:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DW-1:0] m_tdata;

    int unsigned cycle_cnt;
    int unsigned err_cnt;
    int unsigned sent_cnt;
    int unsigned recv_cnt;
    bit          long_hold;      // receiver hold-off requested
    bit          quiet_phase;    // no idling on either side
    bit          sim_done;

    // gamma curve samples, Q.20, built once
    logic [31:0] gamma_lut [TAB_N];

    filmic_tonemap_gamma_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // in_red, in_green, in_blue
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // out_red, out_green, out_blue, pad
    );

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch: %s got %0d want %0d (pixel %0d)", what, got, want, recv_cnt);
        err_cnt++;
    endtask

    // floor of 2^20 * (k/1024)^(5/11), by bisection
    function automatic logic [31:0] gamma_sample(int k);
        logic [511:0] rhs;
        logic [511:0] lhs;
        int lo;
        int hi;
        int mid;
        rhs = 512'(k);
        for (int i = 0; i < 4; i++) rhs = rhs * 512'(k);
        rhs = rhs << (11 * 20);
        lo = 0;
        hi = 1 << 20;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            lhs = 512'(mid);
            for (int i = 0; i < 10; i++) lhs = lhs * 512'(mid);
            lhs = lhs << 50;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return 32'(lo);
    endfunction

    // signed Q.16 curve value for Q8.16 input
    function automatic longint tone_curve(logic [63:0] v);
        longint num;
        logic [63:0] cv;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] t;
        num = longint'(v * (v + 64'd1611)) - 64'sd388853;
        cv  = (64'd64470 * v + 64'd32768) >> 16;
        den = v * (cv + 64'd28374) + 64'd1022550109;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q = mag / den;
        r = mag % den;
        t = q * 64'd65536 + (((r << 16) + den / 2) / den);
        return (num < 0) ? -longint'(t) : longint'(t);
    endfunction

    function automatic logic [15:0] gamma_encode(logic [16:0] x);
        logic [10:0] idx;
        logic [5:0]  frac;
        logic [63:0] y;
        logic [63:0] o;
        idx  = x[16:6];
        frac = x[5:0];
        y = 64'(gamma_lut[idx]);
        if (frac != 0)
            y += ((64'(gamma_lut[idx + 11'd1]) - y) * 64'(frac) + 64'd32) >> 6;
        o = (y + 64'd8) >> 4;
        if (o > 64'hFFFF) o = 64'hFFFF;
        return o[15:0];
    endfunction

    // full pixel path: input matrix, curve, output matrix, clamp, gamma
    function automatic logic [47:0] tonemap_pixel(logic [71:0] px);
        logic [63:0] in_m [3][3] = '{'{39137, 23238, 3161}, '{4981, 59529, 1026},
                                     '{1861, 8771, 54904}};
        longint out_m [3][3] = '{'{105169, -34805, -4828}, '{-6690, 72622, -396},
                                 '{-214, -4768, 70518}};
        logic [63:0] ch [3];
        longint tv [3];
        logic [63:0] s;
        longint w;
        logic [63:0] x;
        logic [47:0] res;
        for (int i = 0; i < 3; i++) ch[i] = 64'(px[24*i +: 24]);
        for (int i = 0; i < 3; i++) begin
            s = '0;
            for (int j = 0; j < 3; j++) s += in_m[i][j] * ch[j];
            s = (s + 64'd32768) >> 16;
            if (s > 64'hFF_FFFF) s = 64'hFF_FFFF;
            tv[i] = tone_curve(s);
        end
        for (int i = 0; i < 3; i++) begin
            w = 0;
            for (int j = 0; j < 3; j++) w += out_m[i][j] * tv[j];
            x = (w <= 0) ? 64'd0 : ((64'(w) + 64'd32768) >> 16);
            if (x > 64'd65536) x = 64'd65536;
            res[16*i +: 16] = gamma_encode(x[16:0]);
        end
        return res;
    endfunction

    class pixel_scoreboard;
        logic [47:0] pending [$];

        function void note_pixel(logic [71:0] px);
            pending.push_back(tonemap_pixel(px));
        endfunction

        task check_pixel(logic [47:0] got);
            logic [47:0] want;
            string names [3] = '{"out_red", "out_green", "out_blue"};
            if (pending.size() == 0) begin
                report_mismatch("unexpected pixel, red", 32'(got[15:0]), 0);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++)
                if (got[16*i +: 16] !== want[16*i +: 16])
                    report_mismatch(names[i], 32'(got[16*i +: 16]),
                                    32'(want[16*i +: 16]));
        endtask
    endclass

    pixel_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input and output transfers, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_pixel(s_tdata);
                sent_cnt++;
            end
            if (m_tvalid && m_tready) begin
                sb.check_pixel(m_tdata[47:0]);
                recv_cnt++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // one pixel, held until the transfer completes, with an optional gap first
    task automatic send_pixel(input logic [71:0] px);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
    endtask

    task automatic drain();
        go_idle();
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_channel();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 255));
            1: return 24'($urandom_range(0, 65536));
            2: return 24'($urandom_range(0, 1 << 20));
            3: return 24'hFF_FFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [23:0] edge_vals [8] = '{24'h0, 24'h1, 24'h100, 24'h8000, 24'h1_0000,
                                       24'h10_0000, 24'h80_0000, 24'hFF_FFFF};
        logic [23:0] c;
        sb = new();
        for (int k = 0; k < TAB_N; k++) gamma_lut[k] = gamma_sample(k);
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        long_hold = 1'b0;
        quiet_phase = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: grey levels across the range, pure primaries, tiny values
        // (negative curve), saturating matrix sums and full white
        foreach (edge_vals[i]) send_pixel({3{edge_vals[i]}});
        foreach (edge_vals[i]) begin
            c = edge_vals[i];
            send_pixel({24'h0, 24'h0, c});
            if (i % 2 == 1) send_pixel({24'h0, c, 24'h0});
            if (i % 2 == 0) send_pixel({c, 24'h0, 24'h0});
        end
        send_pixel({24'hFF_FFFF, 24'h0, 24'hFF_FFFF});

        // sender pause until all pending pixels are out
        drain();

        // fill the pipeline against a held receiver
        long_hold = 1'b1;
        for (int n = 0; n < 60; n++) send_pixel({rand_channel(), rand_channel(),
                                                 rand_channel()});

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) quiet_phase = 1'b1;
            send_pixel({rand_channel(), rand_channel(), rand_channel()});
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("sent %0d pixels, checked %0d, incl. edge levels, primaries, stalls",
                 sent_cnt, recv_cnt);
        if (err_cnt == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d pixels still pending", err_cnt,
                     sb.pending.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
